@@ rtl/sfpp_pkg.sv @@
// Shared types and constants for the sample FIFO PWM player.
// No dependencies; imported by sfpp_ring, sample_fifo_pwm_player_core and tb.
package sfpp_pkg;

  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned FILL_W  = 4;
  localparam int unsigned APB_DW  = 32;
  localparam int unsigned APB_AW  = 3;

  localparam logic [FILL_W-1:0]  FILL_MAX     = 4'hF;
  localparam logic [LEVEL_W-1:0] TICK_DIV_RST = 8'd1;
  localparam logic [LEVEL_W-1:0] IDLE_LVL_RST = 8'd128;
  localparam logic [LEVEL_W-1:0] HELD_LVL_RST = 8'd0;

  // Item kind carried on s_axis_tuser
  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // Register select, paddr[2]
  localparam logic REG_TICK_DIV = 1'b0;
  localparam logic REG_IDLE_LVL = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_POP  = 2'b10
  } state_e;

  typedef struct packed {
    logic              empty;
    logic              full;
    logic [FILL_W-1:0] fill;   // occupancy after this cycle's update, saturated
  } ring_stat_t;

endpackage

@@ rtl/sfpp_ring.sv @@
// Sample ring: synchronous sample memory with write/read indices and count.
// Depends on sfpp_pkg.
module sfpp_ring #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [sfpp_pkg::LEVEL_W-1:0] push_data_i,
  input  logic                         pop_i,
  output logic [sfpp_pkg::LEVEL_W-1:0] rd_data_o,
  output sfpp_pkg::ring_stat_t         stat_o
);
  import sfpp_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);

  logic [LEVEL_W-1:0] mem_q [DEPTH];
  logic [LEVEL_W-1:0] rd_data_q;
  logic [IW-1:0]      wr_idx_q, wr_idx_d;
  logic [IW-1:0]      rd_idx_q, rd_idx_d;
  logic [IW-1:0]      cnt_q, cnt_d;

  function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] idx);
    logic [IW-1:0] n;
    n = (idx == IW'(DEPTH - 1)) ? '0 : idx + 1'b1;
    return n;
  endfunction

  always_comb begin
    wr_idx_d = push_i ? ring_next(wr_idx_q) : wr_idx_q;
    rd_idx_d = pop_i  ? ring_next(rd_idx_q) : rd_idx_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_comb begin
    stat_o.empty = (cnt_q == '0);
    stat_o.full  = (cnt_q == IW'(DEPTH - 1));
    if (32'(cnt_d) > 32'(FILL_MAX)) begin
      stat_o.fill = FILL_MAX;
    end else begin
      stat_o.fill = FILL_W'(cnt_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q <= '0;
      rd_idx_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_idx_q <= wr_idx_d;
      rd_idx_q <= rd_idx_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_idx_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_i) begin
      rd_data_q <= mem_q[rd_idx_q];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/sample_fifo_pwm_player_core.sv @@
// Sample FIFO PWM player top level: stream in/out, APB registers, tick divider.
// Depends on sfpp_pkg and sfpp_ring.
//
// Input items arrive on s_axis: tuser selects push (0) or timer tick (1),
// tdata carries the 8-bit sample for a push. Every item yields exactly one
// result item on m_axis: tdata[7:0] held level, tdata[11:8] ring fill,
// tuser[0] push refused, tuser[1] level changed.
// Pushes and ticks that do not pop have their result registered and presented
// the cycle after acceptance. A tick that pops a sample first reads it into
// the sample memory's read register (state ST_POP), then registers the result.
// s_axis_tready is low while a pop read is in flight and while a result
// waits that the receiver does not take in this cycle; a stalled receiver
// holds the result and back-pressures the input.
// Reset clears the ring (empty), sets the countdown and tick_divide to 1,
// idle_level to 128 and the held level to 0; no memory clearing is needed.
// APB: tick_divide at 0x0, idle_level at 0x4; pready is always high.
module sample_fifo_pwm_player_core #(
  parameter int unsigned RING_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] sample
  input  logic [0:0]  s_axis_tuser,   // [0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] level, [11:8] fill, [15:12] zero
  output logic [1:0]  m_axis_tuser,   // [0] push_refused, [1] level_changed
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sfpp_pkg::*;

  state_e             st_q, st_d;
  logic [LEVEL_W-1:0] tick_div_q, idle_lvl_q;
  logic [LEVEL_W-1:0] cnt_q, cnt_d;
  logic [LEVEL_W-1:0] held_q, held_d;
  logic               m_valid_q, m_valid_d;
  logic [15:0]        m_data_q, m_data_d;
  logic [1:0]         m_user_q, m_user_d;

  logic               accept, is_tick, push_ok, push_ref, pop_req, cfg_wr;
  logic [LEVEL_W-1:0] rd_data;
  ring_stat_t         stat;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_div_q <= TICK_DIV_RST;
      idle_lvl_q <= IDLE_LVL_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_TICK_DIV: tick_div_q <= pwdata[LEVEL_W-1:0];
        REG_IDLE_LVL: idle_lvl_q <= pwdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_TICK_DIV: prdata = APB_DW'(tick_div_q);
      REG_IDLE_LVL: prdata = APB_DW'(idle_lvl_q);
      default:      prdata = '0;
    endcase
  end

  assign s_axis_tready = (st_q == ST_IDLE) && (!m_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_tick       = (s_axis_tuser[0] == ACT_TICK);
  assign push_ok       = accept && !is_tick && !stat.full;
  assign push_ref      = accept && !is_tick && stat.full;
  assign pop_req       = accept && is_tick && (cnt_q == '0) && !stat.empty;

  sfpp_ring #(
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_ok),
    .push_data_i(s_axis_tdata),
    .pop_i      (pop_req),
    .rd_data_o  (rd_data),
    .stat_o     (stat)
  );

  always_comb begin
    st_d      = st_q;
    cnt_d     = cnt_q;
    held_d    = held_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    unique case (st_q)
      ST_IDLE: begin
        if (accept) begin
          if (is_tick) begin
            if (cnt_q == '0) begin
              cnt_d = tick_div_q;
              if (stat.empty) begin
                held_d = idle_lvl_q;
              end
            end else begin
              cnt_d = cnt_q - 1'b1;
            end
          end
          if (pop_req) begin
            st_d = ST_POP;
          end else begin
            m_valid_d = 1'b1;
            m_data_d  = {4'b0, stat.fill, held_d};
            m_user_d  = {is_tick && (cnt_q == '0), push_ref};
          end
        end
      end
      ST_POP: begin
        held_d    = rd_data;
        st_d      = ST_IDLE;
        m_valid_d = 1'b1;
        m_data_d  = {4'b0, stat.fill, rd_data};
        m_user_d  = 2'b10;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      cnt_q     <= TICK_DIV_RST;
      held_q    <= HELD_LVL_RST;
      m_valid_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      cnt_q     <= cnt_d;
      held_q    <= held_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  a_pop_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_POP) |-> !m_valid_q)
    else $error("result register busy during pop read");

  a_pop_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_POP) |=> (m_valid_q && m_user_q[1] && !m_user_q[0]))
    else $error("pop did not produce a level-changed result");

  a_ring_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(stat.full && stat.empty))
    else $error("ring both full and empty");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_req |-> (!stat.empty && !push_ok))
    else $error("pop from empty ring or with concurrent push");

endmodule

@@ tb/tb.sv @@
// Testbench for sample_fifo_pwm_player_core: random push/tick stream, stalled receiver, APB setup.
// Depends on sfpp_pkg and the core RTL; results are predicted from a local copy of ring and divider.
module tb;
  import sfpp_pkg::*;

  localparam int unsigned DEPTH     = 16;
  localparam int unsigned IDX_W     = $clog2(DEPTH);
  localparam int unsigned STALL_LIM = 1000;
  localparam int unsigned DRAIN_AT  = 300;
  localparam int unsigned DRAIN_LEN = 60;
  localparam logic [APB_AW-1:0] TICK_DIV_ADDR = {REG_TICK_DIV, 2'b00};
  localparam logic [APB_AW-1:0] IDLE_LVL_ADDR = {REG_IDLE_LVL, 2'b00};

  typedef struct packed {
    logic               action;
    logic [LEVEL_W-1:0] sample;
  } offer_t;

  typedef struct packed {
    logic               refused;
    logic [LEVEL_W-1:0] level;
    logic               changed;
    logic [FILL_W-1:0]  fill;
  } report_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;   // [7:0] sample
  logic [0:0]  s_axis_tuser  = '0;   // [0] action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // [7:0] level, [11:8] fill, [15:12] zero
  logic [1:0]  m_axis_tuser;         // [0] push_refused, [1] level_changed
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  // local model of the player
  logic [LEVEL_W-1:0] ring_mem [DEPTH];
  int unsigned        wr_ptr, rd_ptr;
  logic [LEVEL_W-1:0] tick_count, out_level, div_reload, idle_value;

  offer_t      offer_q[$];
  report_t     report_q[$];
  offer_t      on_bus;
  int unsigned send_gap, recv_gap, drain_hold;
  int unsigned idle_cycles;
  int unsigned results_seen = 0;
  int unsigned errors       = 0;
  bit          drain_done   = 1'b0;
  bit          steady       = 1'b0;   // no idling in the closing phase

  sample_fifo_pwm_player_core #(
    .RING_DEPTH(DEPTH)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic report_t play_item(offer_t it);
    report_t     r;
    int unsigned nxt;
    int unsigned waiting;
    r = '0;
    if (it.action == ACT_PUSH) begin
      nxt = (wr_ptr + 1) % DEPTH;
      if (nxt != rd_ptr) begin
        ring_mem[wr_ptr[IDX_W-1:0]] = it.sample;
        wr_ptr = nxt;
      end else begin
        r.refused = 1'b1;
      end
    end else if (tick_count == 0) begin
      if (rd_ptr != wr_ptr) begin
        out_level = ring_mem[rd_ptr[IDX_W-1:0]];
        rd_ptr = (rd_ptr + 1) % DEPTH;
      end else begin
        out_level = idle_value;
      end
      r.changed = 1'b1;
      tick_count = div_reload;
    end else begin
      tick_count = tick_count - 1'b1;
    end
    waiting = (wr_ptr + DEPTH - rd_ptr) % DEPTH;
    r.level = out_level;
    r.fill = (waiting > 15) ? FILL_MAX : waiting[FILL_W-1:0];
    return r;
  endfunction

  task automatic add_offer(logic act, logic [LEVEL_W-1:0] smp);
    offer_q.push_back('{action: act, sample: smp});
  endtask

  // sender pauses until every result is back, then lets the pipe drain
  task automatic settle();
    do @(negedge clk_i);
    while (offer_q.size() != 0 || s_axis_tvalid || report_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [APB_AW-1:0] addr, logic [LEVEL_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[LEVEL_W-1:0] !== value) begin
      $error("%s readback: expected %0d, got %0d",
             (addr == TICK_DIV_ADDR) ? "tick_divide" : "idle_level", value,
             prdata[LEVEL_W-1:0]);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    case (addr)
      TICK_DIV_ADDR: div_reload = value;
      IDLE_LVL_ADDR: idle_value = value;
      default: ;
    endcase
  endtask

  task automatic run_phase(logic [LEVEL_W-1:0] div, logic [LEVEL_W-1:0] idle,
                           int unsigned push_pct, int unsigned count);
    reg_write(TICK_DIV_ADDR, div);
    reg_write(IDLE_LVL_ADDR, idle);
    for (int k = 0; k < count; k++) begin
      add_offer(($urandom_range(0, 99) < push_pct) ? ACT_PUSH : ACT_TICK,
                LEVEL_W'($urandom));
    end
    settle();
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      send_gap      <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) report_q.push_back(play_item(on_bus));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap != 0) begin
          s_axis_tvalid <= 1'b0;
          send_gap      <= send_gap - 1;
        end else if (!steady && drain_hold == 0 && $urandom_range(0, 9) == 0) begin
          s_axis_tvalid <= 1'b0;
          send_gap      <= $urandom_range(0, 16);
        end else if (offer_q.size() != 0) begin
          on_bus = offer_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= on_bus.action;
          s_axis_tdata  <= on_bus.sample;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor and checker
  always @(posedge clk_i or negedge rst_ni) begin
    report_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_gap      <= 0;
      drain_hold    <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (report_q.size() == 0) begin
          $error("unexpected result: tdata=%h tuser=%h", m_axis_tdata, m_axis_tuser);
          errors++;
        end else begin
          want = report_q.pop_front();
          if (m_axis_tuser[0] !== want.refused) begin
            $error("push_refused: expected %0d, got %0d", want.refused, m_axis_tuser[0]);
            errors++;
          end
          if (m_axis_tdata[7:0] !== want.level) begin
            $error("level: expected %0d, got %0d", want.level, m_axis_tdata[7:0]);
            errors++;
          end
          if (m_axis_tuser[1] !== want.changed) begin
            $error("level_changed: expected %0d, got %0d", want.changed, m_axis_tuser[1]);
            errors++;
          end
          if (m_axis_tdata[11:8] !== want.fill) begin
            $error("fill: expected %0d, got %0d", want.fill, m_axis_tdata[11:8]);
            errors++;
          end
          if (m_axis_tdata[15:12] !== 4'h0) begin
            $error("tdata pad: expected 0, got %0h", m_axis_tdata[15:12]);
            errors++;
          end
        end
      end
      if (drain_hold != 0) begin
        m_axis_tready <= 1'b0;
        drain_hold    <= drain_hold - 1;
      end else if (!drain_done && results_seen == DRAIN_AT) begin
        drain_done    = 1'b1;
        m_axis_tready <= 1'b0;
        drain_hold    <= DRAIN_LEN;
      end else if (recv_gap != 0) begin
        m_axis_tready <= 1'b0;
        recv_gap      <= recv_gap - 1;
      end else if (!steady && $urandom_range(0, 9) == 0) begin
        m_axis_tready <= 1'b0;
        recv_gap      <= $urandom_range(0, 16);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIM) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [LEVEL_W-1:0] smp;
    wr_ptr     = 0;
    rd_ptr     = 0;
    tick_count = TICK_DIV_RST;
    out_level  = HELD_LVL_RST;
    div_reload = TICK_DIV_RST;
    idle_value = IDLE_LVL_RST;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: two samples out, then an empty-ring load
    add_offer(ACT_PUSH, 8'h00);
    add_offer(ACT_PUSH, 8'hFF);
    repeat (6) add_offer(ACT_TICK, 8'h00);
    settle();

    // zero divider: fill the ring to full, refuse, pop, refill
    reg_write(TICK_DIV_ADDR, 8'd0);
    reg_write(IDLE_LVL_ADDR, 8'hFF);
    for (int k = 0; k < 15; k++) begin
      smp = (k < 8) ? (8'h01 << k) : LEVEL_W'($urandom);
      add_offer(ACT_PUSH, smp);
    end
    add_offer(ACT_PUSH, 8'hA5);
    add_offer(ACT_TICK, 8'h00);
    add_offer(ACT_TICK, 8'h00);
    add_offer(ACT_PUSH, 8'h5A);
    add_offer(ACT_PUSH, 8'h3C);
    settle();

    run_phase(8'd0, 8'd0, 50, 95);
    run_phase(8'd255, 8'd255, 25, 95);
    run_phase(8'd3, LEVEL_W'($urandom), 65, 95);
    run_phase(LEVEL_W'($urandom_range(0, 7)), LEVEL_W'($urandom), 45, 95);
    steady = 1'b1;
    run_phase(8'd1, LEVEL_W'($urandom), 50, 95);

    repeat (8) @(posedge clk_i);
    if (errors == 0 && report_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
